// ----- hdl/slider_crank_piston_kinematics_macros.svh -----
// Assertion helpers used by the top-level RTL.
`ifndef SLIDER_CRANK_PISTON_KINEMATICS_MACROS_SVH
`define SLIDER_CRANK_PISTON_KINEMATICS_MACROS_SVH

`define SCK_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sck: same-cycle check failed");

`define SCK_ASSERT_PAST(label, clk, rst_n, ante, sig, n) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> $past(sig, n)) \
        else $error("sck: latency check failed");

`endif

// ----- hdl/sck_pkg.sv -----
package sck_pkg;

    localparam int XW      = 34;
    localparam int ZW      = 34;
    localparam int SQ_W    = 56;
    localparam int ROOT_W  = 28;
    localparam int NUM_W   = 52;
    localparam int INV_GAIN_Q30 = 652032874;

    typedef enum logic [1:0] {
        REG_CRANK = 2'd0,
        REG_ROD   = 2'd1,
        REG_PIN   = 2'd2,
        REG_BORE  = 2'd3
    } reg_idx_t;

    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] r;
        unique case (idx)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051E;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2F;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2FA;
            15: r = 32'h0000517D;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A30;
            19: r = 32'h00000518;
            20: r = 32'h0000028C;
            21: r = 32'h00000146;
            22: r = 32'h000000A3;
            23: r = 32'h00000051;
            24: r = 32'h00000029;
            25: r = 32'h00000014;
            26: r = 32'h0000000A;
            27: r = 32'h00000005;
            28: r = 32'h00000003;
            29: r = 32'h00000001;
            30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/sck_cordic.sv -----
module sck_cordic
    import sck_pkg::*;
#(
    parameter int STEPS = 18,
    parameter int SW    = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [31:0]         phase,
    input  logic [SW-1:0]       in_side,
    output logic                out_valid,
    output logic signed [31:0]  sin_q,
    output logic signed [31:0]  cos_q,
    output logic [SW-1:0]       out_side
);

    localparam logic signed [XW-1:0] ONE_Q30 = XW'(1073741824);

    logic               v_reg    [0:STEPS];
    logic signed [XW-1:0] x_reg  [0:STEPS];
    logic signed [XW-1:0] y_reg  [0:STEPS];
    logic signed [ZW-1:0] z_reg  [0:STEPS];
    logic               flip_reg [0:STEPS];
    logic [SW-1:0]      side_reg [0:STEPS];

    logic [31:0] ph_rot;
    logic [31:0] p_fold;
    logic        fold_flip;

    logic               out_valid_reg;
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_reg;
    logic [SW-1:0]      out_side_reg;

    function automatic logic signed [31:0] clamp_q30(input logic signed [XW-1:0] v);
        logic signed [31:0] r;
        if (v > ONE_Q30) begin
            r = 32'sh4000_0000;
        end
        else if (v < -ONE_Q30) begin
            r = -32'sh4000_0000;
        end
        else begin
            r = 32'(v);
        end
        return r;
    endfunction

    assign ph_rot    = phase + 32'h4000_0000;
    assign fold_flip = ph_rot[31];
    assign p_fold    = fold_flip ? phase - 32'h8000_0000 : phase;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= XW'(INV_GAIN_Q30);
        y_reg[0]    <= '0;
        z_reg[0]    <= ZW'($signed(p_fold));
        flip_reg[0] <= fold_flip;
        side_reg[0] <= in_side;
    end

    genvar k;
    for (k = 0; k < STEPS; k++)
    begin : g_iter
        logic signed [ZW-1:0] at;
        assign at = ZW'($signed({1'b0, atan_turn(k)}));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (!z_reg[k][ZW-1])
            begin
                x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                z_reg[k+1] <= z_reg[k] - at;
            end
            else
            begin
                x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                z_reg[k+1] <= z_reg[k] + at;
            end
            flip_reg[k+1] <= flip_reg[k];
            side_reg[k+1] <= side_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= v_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        cos_reg      <= flip_reg[STEPS] ? -clamp_q30(x_reg[STEPS]) : clamp_q30(x_reg[STEPS]);
        sin_reg      <= flip_reg[STEPS] ? -clamp_q30(y_reg[STEPS]) : clamp_q30(y_reg[STEPS]);
        out_side_reg <= side_reg[STEPS];
    end

    assign out_valid = out_valid_reg;
    assign sin_q     = sin_reg;
    assign cos_q     = cos_reg;
    assign out_side  = out_side_reg;

endmodule

// ----- hdl/sck_isqrt.sv -----
module sck_isqrt
    import sck_pkg::*;
#(
    parameter int SW = 132
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [SQ_W-1:0]   radicand,
    input  logic [SW-1:0]     in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] root,
    output logic [SW-1:0]     out_side
);

    localparam int STEPS = SQ_W / 2;

    logic            v_reg    [0:STEPS];
    logic [SQ_W-1:0] rem_reg  [0:STEPS];
    logic [SQ_W-1:0] r_reg    [0:STEPS];
    logic [SW-1:0]   side_reg [0:STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= radicand;
        r_reg[0]    <= '0;
        side_reg[0] <= in_side;
    end

    genvar k;
    for (k = 0; k < STEPS; k++)
    begin : g_step
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
        logic [SQ_W-1:0] trial;
        assign trial = r_reg[k] + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rem_reg[k] >= trial)
            begin
                rem_reg[k+1] <= rem_reg[k] - trial;
                r_reg[k+1]   <= (r_reg[k] >> 1) + BIT;
            end
            else
            begin
                rem_reg[k+1] <= rem_reg[k];
                r_reg[k+1]   <= r_reg[k] >> 1;
            end
            side_reg[k+1] <= side_reg[k];
        end
    end

    assign out_valid = v_reg[STEPS];
    assign root      = r_reg[STEPS][ROOT_W-1:0];
    assign out_side  = side_reg[STEPS];

endmodule

// ----- hdl/sck_div.sv -----
module sck_div
    import sck_pkg::*;
#(
    parameter int SW = 103
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  dividend,
    input  logic [ROOT_W-1:0] divisor,
    input  logic [SW-1:0]     in_side,
    output logic              out_valid,
    output logic [NUM_W-1:0]  quotient,
    output logic [SW-1:0]     out_side
);

    logic              v_reg    [0:NUM_W];
    logic [NUM_W-1:0]  num_reg  [0:NUM_W];
    logic [NUM_W-1:0]  q_reg    [0:NUM_W];
    logic [ROOT_W-1:0] rem_reg  [0:NUM_W];
    logic [ROOT_W-1:0] den_reg  [0:NUM_W];
    logic [SW-1:0]     side_reg [0:NUM_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg[0]  <= dividend;
        q_reg[0]    <= '0;
        rem_reg[0]  <= '0;
        den_reg[0]  <= divisor;
        side_reg[0] <= in_side;
    end

    genvar k;
    for (k = 0; k < NUM_W; k++)
    begin : g_step
        logic [ROOT_W:0] trial;
        logic            ge;
        logic [ROOT_W:0] diff;
        assign trial = {rem_reg[k], num_reg[k][NUM_W-1]};
        assign ge    = trial >= {1'b0, den_reg[k]};
        assign diff  = trial - {1'b0, den_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= ge ? diff[ROOT_W-1:0] : trial[ROOT_W-1:0];
            q_reg[k+1]    <= {q_reg[k][NUM_W-2:0], ge};
            num_reg[k+1]  <= num_reg[k] << 1;
            den_reg[k+1]  <= den_reg[k];
            side_reg[k+1] <= side_reg[k];
        end
    end

    assign out_valid = v_reg[NUM_W];
    assign quotient  = q_reg[NUM_W];
    assign out_side  = side_reg[NUM_W];

endmodule

// ----- hdl/slider_crank_piston_kinematics.sv -----
// Channel  | Signals                                             | Direction
// ---------+-----------------------------------------------------+----------
// request  | start, busy, crank_angle, angular_speed             | in, busy out
// result   | done, piston_height, lever_arm, piston_speed,       | out
//          | swept_so_far, geometry_error                        |
// config   | psel, penable, pwrite, paddr, pwdata, prdata, pready| APB
//
// One request is taken every cycle; busy is always low.
// Each result passes through the CORDIC stages, the 28-step root pipeline and
// the 52-step divider pipeline.
// Reset clears all valid bits and returns the registers to their defaults.
// The receiver cannot stall, so the pipeline advances every cycle.
`include "slider_crank_piston_kinematics_macros.svh"

module slider_crank_piston_kinematics
    import sck_pkg::*;
#(
    parameter int ANGLE_BITS   = 16,
    parameter int APPROX_STEPS = 18
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [15:0]         crank_angle,
    input  logic signed [23:0]  angular_speed,
    output logic                done,
    output logic [20:0]         piston_height,
    output logic signed [22:0]  lever_arm,
    output logic signed [40:0]  piston_speed,
    output logic [38:0]         swept_so_far,
    output logic                geometry_error,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam logic [31:0] PHASE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
    localparam int SQ_SW  = 24 + 27 + 27 + 54;
    localparam int DIV_SW = 24 + 27 + 1 + 21 + 30;
    localparam int LAT    = 1 + (APPROX_STEPS + 2) + 2 + (SQ_W / 2 + 1) + (NUM_W + 1) + 3;

    logic [17:0] crank_radius_reg;
    logic [19:0] rod_length_reg;
    logic [17:0] pin_height_reg;
    logic [19:0] bore_area_reg;
    reg_idx_t    cfg_idx;
    logic        cfg_wr;
    logic        geo_err;

    logic               a_valid_reg;
    logic [31:0]        a_phase_reg;
    logic signed [23:0] a_w_reg;

    logic               c_valid;
    logic signed [31:0] c_sin;
    logic signed [31:0] c_cos;
    logic [23:0]        c_w;

    logic               p1_valid_reg;
    logic signed [50:0] p1_ps_reg;
    logic signed [50:0] p1_pc_reg;
    logic [23:0]        p1_w_reg;

    logic signed [26:0] p1_rs;
    logic signed [26:0] p1_rc;

    logic               p2_valid_reg;
    logic signed [26:0] p2_rs_reg;
    logic signed [26:0] p2_rc_reg;
    logic signed [53:0] p2_rs2_reg;
    logic signed [53:0] p2_rsrc_reg;
    logic [39:0]        p2_l2_reg;
    logic [23:0]        p2_w_reg;
    logic [SQ_W-1:0]    sq_arg;

    logic               sq_valid;
    logic [ROOT_W-1:0]  sq_root;
    logic [SQ_SW-1:0]   sq_side;
    logic [23:0]        sq_w;
    logic signed [26:0] sq_rs;
    logic signed [26:0] sq_rc;
    logic signed [53:0] sq_rsrc;
    logic [ROOT_W-1:0]  s_den;
    logic [20:0]        rl_sum;
    logic signed [30:0] hsum;
    logic signed [30:0] dsum;
    logic               num_neg;
    logic [53:0]        num_abs;

    logic               dv_valid;
    logic [NUM_W-1:0]   dv_q;
    logic [DIV_SW-1:0]  dv_side;
    logic [23:0]        dv_w;
    logic signed [26:0] dv_rs;
    logic               dv_neg;
    logic [20:0]        dv_height;
    logic [29:0]        dv_drop;
    logic signed [53:0] q_signed;
    logic signed [54:0] lever_q8;
    logic signed [46:0] arm_full;
    logic signed [22:0] arm_sat;

    logic               p5_valid_reg;
    logic signed [22:0] p5_arm_reg;
    logic [49:0]        p5_swprod_reg;
    logic [20:0]        p5_height_reg;
    logic signed [23:0] p5_w_reg;
    logic [41:0]        sw_round;

    logic               p6_valid_reg;
    logic signed [46:0] p6_spprod_reg;
    logic [38:0]        p6_swept_reg;
    logic signed [22:0] p6_arm_reg;
    logic [20:0]        p6_height_reg;
    logic signed [46:0] sp_round;

    logic               done_reg;
    logic [20:0]        height_out_reg;
    logic signed [22:0] arm_out_reg;
    logic signed [40:0] speed_out_reg;
    logic [38:0]        swept_out_reg;
    logic               geo_out_reg;

    assign busy    = 1'b0;
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign geo_err = {2'b00, crank_radius_reg} >= rod_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crank_radius_reg <= 18'd40000;
            rod_length_reg   <= 20'd140000;
            pin_height_reg   <= 18'd30000;
            bore_area_reg    <= 20'd88672;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_CRANK: crank_radius_reg <= pwdata[17:0];
                REG_ROD:   rod_length_reg   <= pwdata[19:0];
                REG_PIN:   pin_height_reg   <= pwdata[17:0];
                REG_BORE:  bore_area_reg    <= pwdata[19:0];
                default:   crank_radius_reg <= crank_radius_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_CRANK: prdata = {14'd0, crank_radius_reg};
            REG_ROD:   prdata = {12'd0, rod_length_reg};
            REG_PIN:   prdata = {14'd0, pin_height_reg};
            REG_BORE:  prdata = {12'd0, bore_area_reg};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
            p6_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            a_valid_reg  <= start && !busy;
            p1_valid_reg <= c_valid;
            p2_valid_reg <= p1_valid_reg;
            p5_valid_reg <= dv_valid;
            p6_valid_reg <= p5_valid_reg;
            done_reg     <= p6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_phase_reg <= {crank_angle, 16'd0} & PHASE_MASK;
        a_w_reg     <= angular_speed;
    end

    sck_cordic #(
        .STEPS (APPROX_STEPS),
        .SW    (24)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid_reg),
        .phase     (a_phase_reg),
        .in_side   (a_w_reg),
        .out_valid (c_valid),
        .sin_q     (c_sin),
        .cos_q     (c_cos),
        .out_side  (c_w)
    );

    always_ff @(posedge clk)
    begin
        p1_ps_reg <= $signed({1'b0, crank_radius_reg}) * c_sin;
        p1_pc_reg <= $signed({1'b0, crank_radius_reg}) * c_cos;
        p1_w_reg  <= c_w;
    end

    assign p1_rs = p1_ps_reg[48:22];
    assign p1_rc = p1_pc_reg[48:22];

    always_ff @(posedge clk)
    begin
        p2_rs_reg   <= p1_rs;
        p2_rc_reg   <= p1_rc;
        p2_rs2_reg  <= p1_rs * p1_rs;
        p2_rsrc_reg <= p1_rs * p1_rc;
        p2_l2_reg   <= rod_length_reg * rod_length_reg;
        p2_w_reg    <= p1_w_reg;
    end

    assign sq_arg = {p2_l2_reg, 16'd0} - {4'd0, p2_rs2_reg[51:0]};

    sck_isqrt #(
        .SW (SQ_SW)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p2_valid_reg),
        .radicand  (sq_arg),
        .in_side   ({p2_w_reg, p2_rs_reg, p2_rc_reg, p2_rsrc_reg}),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    assign sq_w    = sq_side[131:108];
    assign sq_rs   = sq_side[107:81];
    assign sq_rc   = sq_side[80:54];
    assign sq_rsrc = sq_side[53:0];

    assign s_den   = (sq_root == '0) ? ROOT_W'(1) : sq_root;
    assign rl_sum  = 21'(crank_radius_reg) + 21'(rod_length_reg);
    assign hsum    = 31'(sq_rc) + $signed({3'd0, s_den})
                   + $signed({5'd0, pin_height_reg, 8'h80});
    assign dsum    = $signed({2'd0, rl_sum, 8'd0}) - 31'(sq_rc) - $signed({3'd0, s_den});
    assign num_neg = sq_rsrc[53];
    assign num_abs = num_neg ? 54'(-sq_rsrc) : 54'(sq_rsrc);

    sck_div #(
        .SW (DIV_SW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .dividend  (num_abs[NUM_W-1:0]),
        .divisor   (s_den),
        .in_side   ({sq_w, sq_rs, num_neg, hsum[28:8], dsum[29:0]}),
        .out_valid (dv_valid),
        .quotient  (dv_q),
        .out_side  (dv_side)
    );

    assign dv_w      = dv_side[102:79];
    assign dv_rs     = dv_side[78:52];
    assign dv_neg    = dv_side[51];
    assign dv_height = dv_side[50:30];
    assign dv_drop   = dv_side[29:0];

    assign q_signed = dv_neg ? -$signed({2'd0, dv_q}) : $signed({2'd0, dv_q});
    assign lever_q8 = 55'(dv_rs) + 55'(q_signed) + 55'sd128;
    assign arm_full = 47'(lever_q8 >>> 8);

    always_comb
    begin
        if (arm_full > 47'sd4194303)
        begin
            arm_sat = 23'sh3FFFFF;
        end
        else if (arm_full < -47'sd4194304)
        begin
            arm_sat = 23'sh400000;
        end
        else
        begin
            arm_sat = 23'(arm_full);
        end
    end

    always_ff @(posedge clk)
    begin
        p5_arm_reg    <= arm_sat;
        p5_swprod_reg <= bore_area_reg * dv_drop;
        p5_height_reg <= dv_height;
        p5_w_reg      <= dv_w;
    end

    assign sw_round = 42'((p5_swprod_reg + 50'd128) >> 8);

    always_ff @(posedge clk)
    begin
        p6_spprod_reg <= p5_w_reg * p5_arm_reg;
        p6_swept_reg  <= (sw_round > 42'h7F_FFFF_FFFF) ? 39'h7F_FFFF_FFFF : sw_round[38:0];
        p6_arm_reg    <= p5_arm_reg;
        p6_height_reg <= p5_height_reg;
    end

    assign sp_round = (p6_spprod_reg + 47'sd128) >>> 8;

    always_ff @(posedge clk)
    begin
        geo_out_reg    <= geo_err;
        height_out_reg <= geo_err ? '0 : p6_height_reg;
        arm_out_reg    <= geo_err ? '0 : p6_arm_reg;
        speed_out_reg  <= geo_err ? '0 : 41'(sp_round);
        swept_out_reg  <= geo_err ? '0 : p6_swept_reg;
    end

    assign done           = done_reg;
    assign piston_height  = height_out_reg;
    assign lever_arm      = arm_out_reg;
    assign piston_speed   = speed_out_reg;
    assign swept_so_far   = swept_out_reg;
    assign geometry_error = geo_out_reg;

    `SCK_ASSERT_NOW(a_geo_zero, clk, rst_n, done && geometry_error, piston_height == '0 && lever_arm == '0 && piston_speed == '0 && swept_so_far == '0)
    `SCK_ASSERT_NOW(a_zero_arm_speed, clk, rst_n, done && lever_arm == '0, piston_speed == '0)
    `SCK_ASSERT_PAST(a_latency, clk, rst_n, done, start && !busy, LAT)

endmodule

// ----- dv/slider_crank_piston_kinematics_checker.sv -----
module slider_crank_piston_kinematics_checker
    import sck_pkg::*;
#(
    parameter int ANGLE_BITS   = 16,
    parameter int APPROX_STEPS = 18
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [15:0]        crank_angle,
    input  logic signed [23:0] angular_speed,
    input  logic               done,
    input  logic [20:0]        piston_height,
    input  logic signed [22:0] lever_arm,
    input  logic signed [40:0] piston_speed,
    input  logic [38:0]        swept_so_far,
    input  logic               geometry_error,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 failures,
    output int                 pending,
    output int                 results_seen
);

    typedef struct packed {
        logic [20:0]        height;
        logic signed [22:0] arm;
        logic signed [40:0] speed;
        logic [38:0]        swept;
        logic               geo_err;
    } kin_t;

    kin_t        kin_queue[$];
    logic [17:0] radius_q;
    logic [19:0] rod_q;
    logic [17:0] pin_q;
    logic [19:0] bore_q;

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic kin_t kinematics(logic [15:0] ang, logic signed [23:0] spd);
        kin_t        r;
        logic [31:0] phase;
        logic [31:0] p;
        logic        flip;
        longint      z, x, y, nx, sn, cs, rad, rod, pin, rs, rc, sq, lever, arm, vel;
        logic [63:0] hgt, drop, swp;
        rad = radius_q;
        rod = rod_q;
        pin = pin_q;
        r = '0;
        if (rod_q <= radius_q)
        begin
            r.geo_err = 1'b1;
            return r;
        end
        phase = {ang, 16'd0};
        phase = phase & ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
        flip = ((phase + 32'h40000000) & 32'h80000000) != 0;
        p = flip ? phase - 32'h80000000 : phase;
        z = longint'($signed(p));
        x = INV_GAIN_Q30;
        y = 0;
        for (int i = 0; i < APPROX_STEPS && i < 32; i++)
        begin
            if (z >= 0)
            begin
                nx = x - fshift(y, i);
                y = y + fshift(x, i);
                z = z - longint'(atan_turn(i));
            end
            else
            begin
                nx = x + fshift(y, i);
                y = y - fshift(x, i);
                z = z + longint'(atan_turn(i));
            end
            x = nx;
        end
        x = clampl(x, -(64'sd1 << 30), 64'sd1 << 30);
        y = clampl(y, -(64'sd1 << 30), 64'sd1 << 30);
        cs = flip ? -x : x;
        sn = flip ? -y : y;
        rs = fshift(rad * sn, 22);
        rc = fshift(rad * cs, 22);
        sq = longint'(floor_root(64'(rod * rod) * 64'd65536 - 64'(rs * rs)));
        if (sq < 1)
        begin
            sq = 1;
        end
        hgt = 64'(rc + sq + pin * 256 + 128) >> 8;
        lever = rs + (rs * rc) / sq;
        arm = clampl(fshift(lever + 128, 8), -4194304, 4194303);
        vel = clampl(fshift(longint'(spd) * arm + 128, 8),
            -64'sd1099511627776, 64'sd1099511627775);
        drop = 64'((rad + rod) * 256 - rc - sq);
        swp = (64'(bore_q) * drop + 64'd128) >> 8;
        if (swp > 64'd549755813887)
        begin
            swp = 64'd549755813887;
        end
        r.height = hgt[20:0];
        r.arm = arm[22:0];
        r.speed = vel[40:0];
        r.swept = swp[38:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        kin_t got;
        kin_t want;
        if (!rst_n)
        begin
            radius_q <= 18'd40000;
            rod_q <= 20'd140000;
            pin_q <= 18'd30000;
            bore_q <= 20'd88672;
            failures <= 0;
            results_seen <= 0;
            pending <= 0;
            kin_queue.delete();
        end
        else
        begin
            if (done)
            begin
                got = '{piston_height, lever_arm, piston_speed, swept_so_far, geometry_error};
                results_seen <= results_seen + 1;
                if (kin_queue.size() == 0)
                begin
                    if (failures < 10)
                    begin
                        $display("Unexpected result %p", got);
                    end
                    failures <= failures + 1;
                end
                else
                begin
                    want = kin_queue.pop_front();
                    if (got !== want)
                    begin
                        if (failures < 10)
                        begin
                            $display("Mismatch: expected %p, got %p", want, got);
                        end
                        failures <= failures + 1;
                    end
                end
            end
            if (start && !busy)
            begin
                kin_queue.push_back(kinematics(crank_angle, angular_speed));
            end
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_CRANK: radius_q <= pwdata[17:0];
                    REG_ROD:   rod_q <= pwdata[19:0];
                    REG_PIN:   pin_q <= pwdata[17:0];
                    REG_BORE:  bore_q <= pwdata[19:0];
                    default:   ;
                endcase
            end
            pending <= kin_queue.size();
        end
    end

endmodule

// ----- dv/slider_crank_piston_kinematics_test.sv -----
module slider_crank_piston_kinematics_test;
    import sck_pkg::*;

    localparam int LATENCY = 18 + 90;
    localparam int STALL_LIMIT = 4000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [15:0]        crank_angle;
    logic signed [23:0] angular_speed;
    logic               done;
    logic [20:0]        piston_height;
    logic signed [22:0] lever_arm;
    logic signed [40:0] piston_speed;
    logic [38:0]        swept_so_far;
    logic               geometry_error;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 failures;
    int                 pending;
    int                 results_seen;
    int                 idle_cycles;
    int                 requests_sent;

    slider_crank_piston_kinematics u_top (.*);

    slider_crank_piston_kinematics_checker u_checker (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog expired with %0d results outstanding", pending);
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_geometry(logic [31:0] rad, logic [31:0] rod, logic [31:0] pin,
                                logic [31:0] bore);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 5) @(posedge clk);
        write_reg(REG_CRANK, rad);
        write_reg(REG_ROD, rod);
        write_reg(REG_PIN, pin);
        write_reg(REG_BORE, bore);
    endtask

    task automatic send_request(logic [15:0] ang, logic [23:0] spd);
        start <= 1'b1;
        crank_angle <= ang;
        angular_speed <= spd;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        requests_sent++;
    endtask

    task automatic random_burst(int count, int mode);
        int left;
        int burst;
        logic [15:0] ang;
        logic [23:0] spd;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && left > 0)
            begin
                ang = (mode == 0) ? 16'($urandom) : 16'($urandom_range(0, 7) * 16'h2000
                    + $urandom_range(0, 2) - 1);
                spd = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 24'h800000
                    : 24'h7FFFFF) : 24'($urandom);
                send_request(ang, spd);
                burst--;
                left--;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        start <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] angles[8];
        angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2000, 16'h3FFF,
                   16'h0001};
        rst_n = 1'b0;
        start = 1'b0;
        crank_angle = '0;
        angular_speed = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_cycles = 0;
        requests_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 8; i++)
        begin
            send_request(angles[i], (i % 2) ? 24'h7FFFFF : 24'h800000);
        end
        send_request(16'h1234, 24'h000000);
        start <= 1'b0;

        set_geometry(32'h3FFFF, 32'hFFFFF, 32'h3FFFF, 32'hFFFFF);
        for (int i = 0; i < 8; i++)
        begin
            send_request(angles[i], 24'h800000);
        end
        start <= 1'b0;

        set_geometry(32'd100, 32'd100, 32'd0, 32'd0);
        send_request(16'h1000, 24'h123456);
        send_request(16'h9000, 24'hFFFFFF);
        start <= 1'b0;

        set_geometry(32'd0, 32'd0, 32'd5, 32'd5);
        send_request(16'h5000, 24'h000001);
        start <= 1'b0;

        set_geometry(32'd0, 32'd1, 32'd0, 32'd1);
        send_request(16'h4000, 24'h400000);
        send_request(16'hA5A5, 24'h5A5A5A);
        start <= 1'b0;

        set_geometry(32'd1, 32'd2, 32'd0, 32'd1);
        random_burst(60, 0);

        set_geometry(32'd40000, 32'd140000, 32'd30000, 32'd88672);
        random_burst(300, 0);
        random_burst(100, 1);

        for (int ph = 0; ph < 6; ph++)
        begin
            logic [31:0] rad;
            logic [31:0] rod;
            rad = $urandom_range(1, 262143);
            rod = (ph == 5) ? $urandom_range(1, rad) : $urandom_range(rad + 1, 1048575);
            set_geometry(rad, rod, $urandom, $urandom);
            random_burst(90, ph % 2);
        end

        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 10) @(posedge clk);
        $display("Sent %0d requests across twelve geometry changes, %0d results checked.",
            requests_sent, results_seen);
        if (failures == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
